/* design/linear_quadratic_root_solver_core_macros.svh */
// Assertion macros shared by the root solver RTL.
`ifndef LINEAR_QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define LINEAR_QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define LQRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define LQRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lqrs_pkg.sv */
// Types and constants of the linear and quadratic root solver.
package lqrs_pkg;

    // Coefficient format: signed fixed point, COEF_WIDTH bits, FRAC_BITS fraction bits.
    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Discriminant b*b-4ac at full precision, signed.
    localparam int D_W   = 2 * COEF_WIDTH + 3;
    // Square root result bits and radicand bits (D scaled by 2^(2F)).
    localparam int SQ_R  = COEF_WIDTH + FRAC_BITS + 1;
    localparam int SQ_X  = 2 * SQ_R;
    // Numerator magnitude bits and divisor bits.
    localparam int N_W   = COEF_WIDTH + FRAC_BITS + 2;
    localparam int DEN_W = COEF_WIDTH + 1;

    // Stream widths, padded to whole bytes.
    localparam int IN_DATA_W   = 1 + 3 * COEF_WIDTH;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 2 + 2 * COEF_WIDTH + 2 + 1;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_SOLVED  = 2'd0,
        ST_NO_REAL = 2'd1,
        ST_A_ZERO  = 2'd2
    } t_status;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    // Per-item flags that travel down the pipeline.
    typedef struct packed {
        logic mode;
        logic a_zero;
        logic d_neg;
        logic d_zero;
    } t_flags;

    // Control carried through the divider lanes.
    typedef struct packed {
        t_flags flags;
        logic   neg1;
        logic   neg2;
    } t_dctl;

endpackage

/* design/linear_quadratic_root_solver_core.sv */
// The pipeline has 3 + SQ_R + N_W + 2 register stages; coefficients use the Q16.16 format.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or its transfer completes, so a stall freezes every stage.
// The square root takes one result bit per stage and each divider lane one
// quotient bit per stage. Synchronous active-low reset clears all valid bits.
// Top level of the linear and quadratic real-root solver pipeline.
`include "linear_quadratic_root_solver_core_macros.svh"

module linear_quadratic_root_solver_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // mode, coef_a, coef_b, coef_c from bit 0 up, zero padded
    input  logic [lqrs_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // root_count, root_first, root_second, status, overflow from bit 0 up, zero padded
    output logic [lqrs_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int W     = lqrs_pkg::COEF_WIDTH;
    localparam int F     = lqrs_pkg::FRAC_BITS;
    localparam int SQ_R  = lqrs_pkg::SQ_R;
    localparam int SQ_X  = lqrs_pkg::SQ_X;
    localparam int D_W   = lqrs_pkg::D_W;
    localparam int N_W   = lqrs_pkg::N_W;
    localparam int DEN_W = lqrs_pkg::DEN_W;

    logic w_en;
    logic w_in_xfer;

    // Input stage.
    logic                r1_vld;
    logic                r1_mode;
    lqrs_pkg::t_coef     r1_a, r1_b, r1_c;

    // Product stage.
    logic                       r2_vld;
    logic                       r2_mode;
    lqrs_pkg::t_coef            r2_a, r2_b;
    logic signed [2*W-1:0]      r2_bb, r2_ac;

    // Square root stages; index 0 is loaded from the discriminant.
    logic                       r_sq_vld   [0:SQ_R];
    lqrs_pkg::t_flags           r_sq_flags [0:SQ_R];
    lqrs_pkg::t_coef            r_sq_a     [0:SQ_R];
    lqrs_pkg::t_coef            r_sq_b     [0:SQ_R];
    logic [SQ_X-1:0]            r_sq_rad   [0:SQ_R];
    logic [SQ_R:0]              r_sq_rem   [0:SQ_R];
    logic [SQ_R-1:0]            r_sq_root  [0:SQ_R];

    // Divider stages, two lanes sharing one divisor.
    logic                       r_dv_vld   [0:N_W];
    lqrs_pkg::t_dctl            r_dv_ctl   [0:N_W];
    logic [DEN_W-1:0]           r_dv_den   [0:N_W];
    logic [N_W-1:0]             r_dv_num   [0:N_W][0:1];
    logic [DEN_W-1:0]           r_dv_rem   [0:N_W][0:1];

    // Output register.
    logic                       r_out_vld;
    logic [1:0]                 r_out_count;
    logic [W-1:0]               r_out_first;
    logic [W-1:0]               r_out_second;
    lqrs_pkg::t_status          r_out_status;
    logic                       r_out_ovf;

    // The pipeline moves as one unit whenever the output can take a result.
    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;
    assign w_in_xfer  = i_s_tvalid && w_en;

    // Valid bits for the fixed stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_s_tvalid;
            r2_vld <= r1_vld;
        end
    end

    // Capture the coefficients of each transfer.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode <= i_s_tdata[0];
            r1_a    <= i_s_tdata[W:1];
            r1_b    <= i_s_tdata[2*W:W+1];
            r1_c    <= i_s_tdata[3*W:2*W+1];
        end
    end

    // Products b*b and a*c.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mode <= r1_mode;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_bb   <= (2*W)'(r1_b) * (2*W)'(r1_b);
            r2_ac   <= (2*W)'(r1_a) * (2*W)'(r1_c);
        end
    end

    // Discriminant and load of the square root radicand.
    logic signed [D_W-1:0] n_disc;
    assign n_disc = $signed({3'b000, r2_bb}) - $signed({r2_ac[2*W-1], r2_ac, 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= r2_vld;
        end
    end

    // A linear equation or a negative discriminant feeds a zero radicand.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_flags[0].mode   <= r2_mode;
            r_sq_flags[0].a_zero <= (r2_a == '0);
            r_sq_flags[0].d_neg  <= n_disc[D_W-1];
            r_sq_flags[0].d_zero <= (n_disc == '0);
            r_sq_a[0]            <= r2_a;
            r_sq_b[0]            <= r2_b;
            r_sq_rad[0]          <= (n_disc[D_W-1] || !r2_mode) ? '0
                                    : {1'b0, n_disc[2*W:0], {(2*F){1'b0}}};
            r_sq_rem[0]          <= '0;
            r_sq_root[0]         <= '0;
        end
    end

    // Square root: one result bit per stage, two radicand bits brought down.
    for (genvar k = 0; k < SQ_R; k++) begin : g_sqrt
        logic [SQ_R+2:0] n_rem2;
        logic [SQ_R+2:0] n_trial;
        logic            n_ge;

        assign n_rem2  = {r_sq_rem[k], r_sq_rad[k][SQ_X-1:SQ_X-2]};
        assign n_trial = {1'b0, r_sq_root[k], 2'b01};
        assign n_ge    = (n_rem2 >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_flags[k+1] <= r_sq_flags[k];
                r_sq_a[k+1]     <= r_sq_a[k];
                r_sq_b[k+1]     <= r_sq_b[k];
                r_sq_rad[k+1]   <= {r_sq_rad[k][SQ_X-3:0], 2'b00};
                r_sq_rem[k+1]   <= n_ge ? (SQ_R+1)'(n_rem2 - n_trial) : (SQ_R+1)'(n_rem2);
                r_sq_root[k+1]  <= {r_sq_root[k][SQ_R-2:0], n_ge};
            end
        end
    end

    // Numerators -b*2^F +/- sqrt and the divisor a or 2a.
    logic signed [W+F-1:0] n_bsh;
    logic signed [N_W:0]   n_nb, n_s, n_n1, n_n2;
    logic [W-1:0]          n_amag;
    lqrs_pkg::t_coef       n_fa;

    assign n_fa   = r_sq_a[SQ_R];
    assign n_bsh  = {r_sq_b[SQ_R], {F{1'b0}}};
    assign n_nb   = -((N_W+1)'(n_bsh));
    assign n_s    = $signed({2'b00, r_sq_root[SQ_R]});
    assign n_n1   = n_nb + n_s;
    assign n_n2   = n_nb - n_s;
    assign n_amag = n_fa[W-1] ? W'(-n_fa) : W'(n_fa);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_sq_vld[SQ_R];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_ctl[0].flags <= r_sq_flags[SQ_R];
            r_dv_ctl[0].neg1  <= n_n1[N_W] ^ n_fa[W-1];
            r_dv_ctl[0].neg2  <= n_n2[N_W] ^ n_fa[W-1];
            r_dv_den[0]       <= r_sq_flags[SQ_R].mode ? {n_amag, 1'b0} : {1'b0, n_amag};
            r_dv_num[0][0]    <= n_n1[N_W] ? N_W'(-n_n1) : N_W'(n_n1);
            r_dv_num[0][1]    <= n_n2[N_W] ? N_W'(-n_n2) : N_W'(n_n2);
            r_dv_rem[0][0]    <= '0;
            r_dv_rem[0][1]    <= '0;
        end
    end

    // Restoring division: one quotient bit per stage and lane.
    for (genvar k = 0; k < N_W; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_ctl[k+1] <= r_dv_ctl[k];
                r_dv_den[k+1] <= r_dv_den[k];
            end
        end

        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic [DEN_W:0] n_rem2;
            logic           n_ge;

            assign n_rem2 = {r_dv_rem[k][j], r_dv_num[k][j][N_W-1]};
            assign n_ge   = (n_rem2 >= {1'b0, r_dv_den[k]});

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_rem[k+1][j] <= n_ge ? DEN_W'(n_rem2 - {1'b0, r_dv_den[k]})
                                             : DEN_W'(n_rem2);
                    r_dv_num[k+1][j] <= {r_dv_num[k][j][N_W-2:0], n_ge};
                end
            end
        end
    end

    // Round to nearest, ties away from zero, then saturate and apply the sign.
    logic [W-1:0] n_res  [0:1];
    logic         n_sat  [0:1];
    logic         n_negl [0:1];

    assign n_negl[0] = r_dv_ctl[N_W].neg1;
    assign n_negl[1] = r_dv_ctl[N_W].neg2;

    for (genvar j = 0; j < 2; j++) begin : g_round
        logic           n_up;
        logic [N_W:0]   n_qr;
        logic [N_W:0]   n_lim;
        logic [N_W:0]   n_val;

        assign n_up  = ({r_dv_rem[N_W][j], 1'b0} >= {1'b0, r_dv_den[N_W]});
        assign n_qr  = {1'b0, r_dv_num[N_W][j]} + (N_W+1)'(n_up);
        assign n_lim = n_negl[j] ? ((N_W+1)'(1) << (W-1))
                                 : (((N_W+1)'(1) << (W-1)) - (N_W+1)'(1));
        assign n_sat[j] = (n_qr > n_lim);
        assign n_val    = n_sat[j] ? n_lim : n_qr;
        assign n_res[j] = n_negl[j] ? (-n_val[W-1:0]) : n_val[W-1:0];
    end

    // Result classification.
    lqrs_pkg::t_flags  n_fl;
    lqrs_pkg::t_status n_status;
    logic [1:0]        n_count;

    assign n_fl = r_dv_ctl[N_W].flags;

    always_comb begin
        priority if (n_fl.a_zero) begin
            n_status = lqrs_pkg::ST_A_ZERO;
            n_count  = 2'd0;
        end else if (!n_fl.mode || n_fl.d_zero) begin
            n_status = lqrs_pkg::ST_SOLVED;
            n_count  = 2'd1;
        end else if (n_fl.d_neg) begin
            n_status = lqrs_pkg::ST_NO_REAL;
            n_count  = 2'd0;
        end else begin
            n_status = lqrs_pkg::ST_SOLVED;
            n_count  = 2'd2;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[N_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_count  <= n_count;
            r_out_status <= n_status;
            r_out_first  <= (n_count != 2'd0) ? n_res[0] : '0;
            r_out_second <= (n_count == 2'd2) ? n_res[1] : '0;
            r_out_ovf    <= ((n_count != 2'd0) && n_sat[0]) || ((n_count == 2'd2) && n_sat[1]);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = lqrs_pkg::OUT_TDATA_W'({r_out_ovf, r_out_status, r_out_second,
                                                r_out_first, r_out_count});

    // Checks on the result classification and stage loading.
    `LQRS_ASSERT_NOW(a_unsolved_empty, i_clk, i_rst_n,
        r_out_vld && (r_out_status != lqrs_pkg::ST_SOLVED),
        (r_out_count == 2'd0) && (r_out_first == '0) && (r_out_second == '0) && !r_out_ovf,
        "unsolved result carries roots")
    `LQRS_ASSERT_NOW(a_solved_count, i_clk, i_rst_n,
        r_out_vld && (r_out_status == lqrs_pkg::ST_SOLVED),
        (r_out_count == 2'd1) || (r_out_count == 2'd2),
        "solved result without roots")
    `LQRS_ASSERT_NOW(a_second_zero, i_clk, i_rst_n,
        r_out_vld && (r_out_count == 2'd1),
        r_out_second == '0,
        "single root result has a second root")
    `LQRS_ASSERT_NEXT(a_input_loaded, i_clk, i_rst_n,
        w_in_xfer,
        r1_vld,
        "accepted transfer did not enter the pipeline")

endmodule
